FILE: rtl/ttbm_pkg.sv
// Shared types and constants for the threshold table best-match block.
package ttbm_pkg;

	localparam int VAL_W  = 16;
	localparam int IDX_W  = 4;
	localparam int COST_W = 40;
	localparam int INC_W  = 32;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// register select is paddr[2]
	localparam logic REG_ROWS_IN_USE  = 1'b0;
	localparam logic REG_REACH_MARGIN = 1'b1;

	localparam logic [4:0]       ROWS_IN_USE_RST  = 5'd1;
	localparam logic [VAL_W-1:0] REACH_MARGIN_RST = 16'd256;

	// word moving down the cell chain, with the running best-match result
	typedef struct packed {
		logic              vld;
		logic              mode;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  elem;
		logic [VAL_W-1:0]  value;
		logic              last;
		logic              seen;
		logic              any;
		logic [IDX_W-1:0]  best_row;
		logic [COST_W-1:0] best_cost;
	} tok_t;

	typedef struct packed {
		logic              any_reached;
		logic [IDX_W-1:0]  best_row;
		logic [COST_W-1:0] best_cost;
	} res_t;

endpackage

FILE: rtl/ttbm_if.sv
// Valid/ready channel interfaces for input items and result words.
interface ttbm_in_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [ttbm_pkg::IDX_W-1:0] row_index;
	logic [ttbm_pkg::IDX_W-1:0] element_index;
	logic signed [ttbm_pkg::VAL_W-1:0] sample_value;
	logic                       last_element;

	modport source(output valid, mode, row_index, element_index, sample_value,
		last_element, input ready);
	modport sink(input valid, mode, row_index, element_index, sample_value,
		last_element, output ready);
endinterface

interface ttbm_out_if;
	logic                        valid;
	logic                        ready;
	logic                        any_reached;
	logic [ttbm_pkg::IDX_W-1:0]  best_row;
	logic [ttbm_pkg::COST_W-1:0] best_cost;

	modport source(output valid, any_reached, best_row, best_cost, input ready);
	modport sink(input valid, any_reached, best_row, best_cost, output ready);
endinterface

FILE: rtl/ttbm_cell.sv
// One table row: reference memory, cost accumulator and best-match compare stage.
module ttbm_cell #(
	parameter int IDX  = 0,
	parameter int DIMS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ttbm_pkg::VAL_W-1:0] margin,
	input  logic                       in_use,
	input  ttbm_pkg::tok_t             tok_i,
	output ttbm_pkg::tok_t             tok_o
);

	localparam int AW = (DIMS > 1) ? $clog2(DIMS) : 1;

	logic [ttbm_pkg::VAL_W-1:0] ref_mem [DIMS];
	logic [AW-1:0]              addr;
	logic                       wr_en;

	ttbm_pkg::tok_t             tok_s1;
	logic [ttbm_pkg::VAL_W-1:0] rd_s1;

	ttbm_pkg::tok_t             tok_s2;
	logic [ttbm_pkg::INC_W-1:0] inc_s2;
	logic                       over_s2;

	logic [ttbm_pkg::COST_W-1:0] cost_q;
	logic                        reach_q;

	logic                        active_s1;
	logic signed [16:0]          d;
	logic signed [16:0]          neg_d;
	logic                        pos;
	logic [15:0]                 mag;
	logic [ttbm_pkg::INC_W-1:0]  prod;
	logic [ttbm_pkg::INC_W-1:0]  inc;

	logic [ttbm_pkg::COST_W:0]   sum;
	logic [ttbm_pkg::COST_W-1:0] cost_new;
	logic                        reach_new;
	logic                        is_query;
	logic                        is_end;

	assign addr  = AW'(tok_i.elem);
	assign wr_en = tok_i.vld && (tok_i.mode == ttbm_pkg::MODE_WRITE)
		&& (32'(tok_i.row) == IDX) && (32'(tok_i.elem) < DIMS);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ref_mem[addr] <= tok_i.value;
		end
		rd_s1 <= ref_mem[addr];
	end

	// stage 1: difference (ref minus query); square if positive, else magnitude times 256
	assign active_s1 = tok_s1.vld && (tok_s1.mode == ttbm_pkg::MODE_QUERY)
		&& (32'(tok_s1.elem) < DIMS);
	assign d     = $signed({rd_s1[15], rd_s1}) - $signed({tok_s1.value[15], tok_s1.value});
	assign neg_d = -d;
	assign pos   = !d[16] && (d != 17'sd0);
	assign mag   = pos ? d[15:0] : neg_d[15:0];
	assign prod  = mag * mag;
	assign inc   = pos ? prod : {8'd0, mag, 8'd0};

	// stage 2: saturating accumulate, then fold into the running best
	assign sum       = {1'b0, cost_q} + {9'd0, inc_s2};
	assign cost_new  = sum[ttbm_pkg::COST_W] ? ttbm_pkg::COST_MAX
		: sum[ttbm_pkg::COST_W-1:0];
	assign reach_new = reach_q && !over_s2;
	assign is_query  = tok_s2.vld && (tok_s2.mode == ttbm_pkg::MODE_QUERY);
	assign is_end    = is_query && tok_s2.last;

	always_comb begin
		tok_o = tok_s2;
		if (is_end && in_use) begin
			tok_o.any = tok_s2.any || reach_new;
			if (!tok_s2.seen || (cost_new < tok_s2.best_cost)) begin
				tok_o.seen      = 1'b1;
				tok_o.best_row  = ttbm_pkg::IDX_W'(IDX);
				tok_o.best_cost = cost_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			tok_s2  <= '0;
			cost_q  <= '0;
			reach_q <= 1'b1;
		end else begin
			tok_s1 <= tok_i;
			tok_s2 <= tok_s1;
			if (is_end) begin
				cost_q  <= '0;
				reach_q <= 1'b1;
			end else if (is_query) begin
				cost_q  <= cost_new;
				reach_q <= reach_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		inc_s2  <= active_s1 ? inc : '0;
		over_s2 <= active_s1 && pos && (mag > margin);
	end

endmodule

FILE: rtl/ttbm_obuf.sv
// Two-word result buffer between the cell chain and the result channel.
module ttbm_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ttbm_pkg::res_t    push_word,
	output logic [1:0]        level,
	ttbm_out_if.source        results
);

	ttbm_pkg::res_t ent0_q;
	ttbm_pkg::res_t ent1_q;
	logic [1:0]     cnt_q;
	logic           pop;

	assign pop                 = results.valid && results.ready;
	assign level               = cnt_q;
	assign results.valid       = (cnt_q != 2'd0);
	assign results.any_reached = ent0_q.any_reached;
	assign results.best_row    = ent0_q.best_row;
	assign results.best_cost   = ent0_q.best_cost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= push_word;
				end else begin
					ent1_q <= push_word;
				end
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent0_q <= push_word;
				end else begin
					ent0_q <= ent1_q;
					ent1_q <= push_word;
				end
			end
			default: begin
				ent0_q <= ent0_q;
			end
		endcase
	end

endmodule

FILE: rtl/threshold_table_best_match_top.sv
// Top level: input staging, config registers, row-cell chain and result buffer.
//
// Usage
//   items   : valid/ready input channel. mode 0 writes one table element
//             (row_index, element_index, sample_value); mode 1 feeds one query
//             element, last_element closes the query vector.
//   results : one word per closed query: any_reached, best_row, best_cost.
//   APB     : rows_in_use at 0x0, reach_margin at 0x4 (decoded on paddr[2]);
//             write only while no item is in flight.
// Pipeline
//   Each accepted word is registered in the input stage, then runs down a
//   chain of ROWS cells, each holding it in its stage 1 and stage 2 registers;
//   a query result is pushed into the buffer as its last element leaves the
//   chain. One word is in the chain at a time.
// Reset
//   Costs clear to zero, every row counts as reached, rows_in_use = 1,
//   reach_margin = 1.0. Table contents are unknown until written.
// Stalls
//   A two-word buffer holds results; items are taken while at most one
//   result waits, so the next item proceeds while a result sits unread.
module threshold_table_best_match_top #(
	parameter int ROWS = 16,
	parameter int DIMS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ttbm_in_if.sink     items,
	ttbm_out_if.source  results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [4:0]                 rows_q;
	logic [ttbm_pkg::VAL_W-1:0] margin_q;
	logic                       cfg_wr;

	ttbm_pkg::tok_t chain [ROWS+1];
	logic [ROWS-1:0] row_on;

	ttbm_pkg::tok_t inj_q;
	logic           busy_q;
	logic           accept;
	logic [1:0]     level;
	logic           push;
	ttbm_pkg::res_t push_word;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ttbm_pkg::ROWS_IN_USE_RST;
			margin_q <= ttbm_pkg::REACH_MARGIN_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				ttbm_pkg::REG_ROWS_IN_USE:  rows_q   <= pwdata[4:0];
				ttbm_pkg::REG_REACH_MARGIN: margin_q <= pwdata[15:0];
				default:                    rows_q   <= rows_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ttbm_pkg::REG_ROWS_IN_USE:  prdata = {27'd0, rows_q};
			ttbm_pkg::REG_REACH_MARGIN: prdata = {16'd0, margin_q};
			default:                    prdata = '0;
		endcase
	end

	// input staging
	assign items.ready = !busy_q && (level != 2'd2);
	assign accept      = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			inj_q.vld <= accept;
			if (accept) begin
				inj_q.mode      <= items.mode;
				inj_q.row       <= items.row_index;
				inj_q.elem      <= items.element_index;
				inj_q.value     <= items.sample_value;
				inj_q.last      <= items.last_element;
				inj_q.seen      <= 1'b0;
				inj_q.any       <= 1'b0;
				inj_q.best_row  <= '0;
				inj_q.best_cost <= '0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (chain[ROWS].vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	// cell chain
	assign chain[0] = inj_q;

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		// rows_in_use of zero still keeps row 0
		assign row_on[r] = (r == 0) || (32'(rows_q) > r);

		ttbm_cell #(
			.IDX  (r),
			.DIMS (DIMS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.margin (margin_q),
			.in_use (row_on[r]),
			.tok_i  (chain[r]),
			.tok_o  (chain[r+1])
		);
	end

	// result buffer
	assign push = chain[ROWS].vld && (chain[ROWS].mode == ttbm_pkg::MODE_QUERY)
		&& chain[ROWS].last;
	assign push_word.any_reached = chain[ROWS].any;
	assign push_word.best_row    = chain[ROWS].best_row;
	assign push_word.best_cost   = chain[ROWS].best_cost;

	ttbm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.level     (level),
		.results   (results)
	);

	a_tail_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ROWS].vld |-> busy_q)
		else $error("word left the chain while block idle");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level != 2'd2))
		else $error("result pushed into a full buffer");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level != 2'd3)
		else $error("result buffer level out of range");

	a_accept_injects: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (inj_q.vld && busy_q))
		else $error("accepted item not injected into chain");

endmodule
